FILE: sv/fprx_pkg.sv
// Shared types and codes for the framed packet receiver.
`default_nettype none

package fprx_pkg;

	// Default depth of the payload store
	localparam int unsigned PAYLOAD_DEPTH_DEF = 256;

	// Input word opcodes
	typedef enum logic {
		OP_RX   = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_ACCEPT   = 3'd1,
		ST_CHK_DROP = 3'd2,
		ST_END_DROP = 3'd3,
		ST_IGNORED  = 3'd4,
		ST_READ     = 3'd5
	} status_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_START_MARKER = 1'b0,
		CFG_END_MARKER   = 1'b1
	} cfg_index_t;

	// Receiver phase, one-hot
	typedef enum logic [5:0] {
		PH_HUNT = 6'b000001,
		PH_LEN  = 6'b000010,
		PH_DATA = 6'b000100,
		PH_CHK  = 6'b001000,
		PH_END  = 6'b010000,
		PH_DONE = 6'b100000
	} phase_t;

	// Store write request from the deframer
	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} store_wr_t;

	// Per-word result from the deframer
	typedef struct packed {
		status_t    status;
		logic       frame_ok;
		logic [7:0] payload_length;
	} frame_res_t;

endpackage

`default_nettype wire

FILE: sv/fprx_store.sv
// Payload byte store: one write port, one registered read port.
`default_nettype none

module fprx_store #(
	parameter int unsigned PAYLOAD_DEPTH = fprx_pkg::PAYLOAD_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire fprx_pkg::store_wr_t wr,
	input  wire logic                rd_en,
	input  wire logic [7:0]          rd_addr,
	output logic [7:0]               rd_data
);
	import fprx_pkg::*;

	localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic [7:0] mem_q [PAYLOAD_DEPTH];
	logic [7:0] rd_data_q;

	// Write one payload byte
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	// Read and hold until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/fprx_deframer.sv
// Frame parser: phase, length, position and checksum state with store writes.
`default_nettype none

module fprx_deframer #(
	parameter int unsigned PAYLOAD_DEPTH = fprx_pkg::PAYLOAD_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire fprx_pkg::opcode_t    opcode,
	input  wire logic [7:0]           rx_byte,
	input  wire logic [7:0]           start_marker,
	input  wire logic [7:0]           end_marker,
	output fprx_pkg::frame_res_t      res,
	output fprx_pkg::store_wr_t       wr
);
	import fprx_pkg::*;

	localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

	phase_t     phase_q, phase_d;
	logic [7:0] frame_length_q, frame_length_d;
	logic [7:0] byte_position_q, byte_position_d;
	logic [7:0] running_sum_q, running_sum_d;
	logic [7:0] pos_inc;
	status_t    status_d;
	logic       ok_d;
	logic       wr_en_d;

	assign pos_inc = byte_position_q + 8'd1;

	// Next state for one link word
	always_comb begin
		phase_d         = phase_q;
		frame_length_d  = frame_length_q;
		byte_position_d = byte_position_q;
		running_sum_d   = running_sum_q;
		status_d        = ST_BUSY;
		ok_d            = 1'b0;
		wr_en_d         = 1'b0;
		if (opcode == OP_READ) begin
			status_d = ST_READ;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == start_marker) begin
						running_sum_d   = '0;
						byte_position_d = '0;
						phase_d         = PH_LEN;
					end else begin
						status_d = ST_IGNORED;
					end
				end
				PH_LEN: begin
					frame_length_d = rx_byte;
					phase_d        = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
				end
				PH_DATA: begin
					wr_en_d         = ({1'b0, byte_position_q} < DEPTH_W);
					running_sum_d   = running_sum_q + rx_byte;
					byte_position_d = pos_inc;
					if (pos_inc >= frame_length_q) begin
						phase_d = PH_CHK;
					end
				end
				PH_CHK: begin
					if (rx_byte == running_sum_q) begin
						phase_d = PH_END;
					end else begin
						phase_d         = PH_HUNT;
						frame_length_d  = '0;
						byte_position_d = '0;
						running_sum_d   = '0;
						status_d        = ST_CHK_DROP;
					end
				end
				PH_END: begin
					if (rx_byte == end_marker) begin
						phase_d  = PH_DONE;
						status_d = ST_ACCEPT;
						ok_d     = 1'b1;
					end else begin
						phase_d         = PH_HUNT;
						frame_length_d  = '0;
						byte_position_d = '0;
						running_sum_d   = '0;
						status_d        = ST_END_DROP;
					end
				end
				default: begin
					// Word after an accepted frame: consume it and rehunt
					phase_d         = PH_HUNT;
					frame_length_d  = '0;
					byte_position_d = '0;
					running_sum_d   = '0;
					status_d        = ST_IGNORED;
				end
			endcase
		end
	end

	// Advance state on each word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			frame_length_q  <= '0;
			byte_position_q <= '0;
			running_sum_q   <= '0;
		end else if (step) begin
			phase_q         <= phase_d;
			frame_length_q  <= frame_length_d;
			byte_position_q <= byte_position_d;
			running_sum_q   <= running_sum_d;
		end
	end

	assign res.status         = status_d;
	assign res.frame_ok       = ok_d;
	assign res.payload_length = frame_length_d;

	assign wr.en   = step && wr_en_d;
	assign wr.addr = byte_position_q;
	assign wr.data = rx_byte;

endmodule

`default_nettype wire

FILE: sv/framed_packet_receiver_core.sv
// Top level of the framed packet receiver: input register, parser, store, result register.
`default_nettype none

// Deframes start marker / length / payload / additive checksum / end marker
// frames from a byte link and answers reads of the stored payload. One word
// is taken every cycle unless the input is stalled; each word goes through an
// input register and a result register before its result reaches the outputs.
// The parser makes at most one store write per word; the payload store has one
// write port and one registered read port, and reads see every earlier payload
// write. The store is not cleared after reset and needs no clearing pass.
// Configuration (markers) is written through a port that is always ready.

module framed_packet_receiver_core #(
	parameter int unsigned PAYLOAD_DEPTH = fprx_pkg::PAYLOAD_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Input words
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       opcode,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] read_index,
	// Results
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output logic            frame_ok,
	output logic [7:0]      payload_length,
	output logic [7:0]      read_data,
	// Configuration writes
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);
	import fprx_pkg::*;

	localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

	logic       valid_s1;
	opcode_t    opcode_s1;
	logic [7:0] rx_byte_s1;
	logic [7:0] read_index_s1;

	logic       valid_s2;
	status_t    status_s2;
	logic       frame_ok_s2;
	logic [7:0] payload_length_s2;
	logic       rd_ok_s2;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;

	logic       adv_s2;
	logic       adv_s1;
	logic       take;
	logic       rd_en;
	logic [7:0] rd_data;

	frame_res_t res;
	store_wr_t  wr;

	// Handshake: result register frees when empty or drained
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign take     = in_valid && !in_stall;
	assign rd_en    = adv_s1 && (opcode_s1 == OP_READ);

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= 8'd2;
			end_marker_q   <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_START_MARKER: start_marker_q <= cfg_data;
				CFG_END_MARKER:   end_marker_q   <= cfg_data;
				default:          start_marker_q <= start_marker_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take || adv_s1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			opcode_s1     <= opcode_t'(opcode);
			rx_byte_s1    <= rx_byte;
			read_index_s1 <= read_index;
		end
	end

	fprx_deframer #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s1),
		.opcode       (opcode_s1),
		.rx_byte      (rx_byte_s1),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.res          (res),
		.wr           (wr)
	);

	fprx_store #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (read_index_s1),
		.rd_data (rd_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2         <= res.status;
			frame_ok_s2       <= res.frame_ok;
			payload_length_s2 <= res.payload_length;
			rd_ok_s2          <= (opcode_s1 == OP_READ) &&
				({1'b0, read_index_s1} < DEPTH_W);
		end
	end

	assign out_valid      = valid_s2;
	assign status         = status_s2;
	assign frame_ok       = frame_ok_s2;
	assign payload_length = payload_length_s2;
	assign read_data      = rd_ok_s2 ? rd_data : 8'd0;

endmodule

`default_nettype wire

FILE: sv/fprx_checker.sv
// Port-level checks for the framed packet receiver and their binding.
`default_nettype none

module fprx_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] status,
	input wire logic       frame_ok,
	input wire logic [7:0] payload_length,
	input wire logic [7:0] read_data
);
	import fprx_pkg::*;

	// Frame completion flag only with an accept status
	a_ok_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ok |-> status == ST_ACCEPT)
		else $error("frame_ok without accept status");

	// Read data stays zero outside read replies
	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_READ |-> read_data == 8'd0)
		else $error("read_data nonzero on a non-read result");

	// Drops clear the frame length
	a_drop_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_CHK_DROP || status == ST_END_DROP)
		|-> payload_length == 8'd0)
		else $error("payload_length nonzero on a dropped frame");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(payload_length) && $stable(read_data))
		else $error("stalled result changed");

endmodule

bind framed_packet_receiver_core fprx_checker u_fprx_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.frame_ok       (frame_ok),
	.payload_length (payload_length),
	.read_data      (read_data)
);

`default_nettype wire
